/* design/ostq_pkg.sv */
// shared types and codes for the one-shot timeout slots and event ring
// no dependencies; imported by every module of the block
package ostq_pkg;

	localparam int unsigned TOKEN_W = 16;
	localparam int unsigned ID_W    = 31;
	localparam int unsigned DELAY_W = 24;

	typedef enum logic [2:0] {
		OP_POST  = 3'd0,
		OP_ADD   = 3'd1,
		OP_DEL   = 3'd2,
		OP_TICK  = 3'd3,
		OP_DEQ   = 3'd4,
		OP_SHUT  = 3'd5,
		OP_NONE6 = 3'd6,
		OP_NONE7 = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_NO_SLOT = 3'd2,
		ST_SHUT    = 3'd3,
		ST_EMPTY   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_ADD,
		S_EXP,
		S_READ,
		S_RESP
	} state_t;

	// one timeout slot as it travels along the cell row
	typedef struct packed {
		logic [TOKEN_W-1:0] token;
		logic [ID_W-1:0]    id;
		logic [DELAY_W-1:0] rem;
		logic               nodel;
	} slot_t;

	// one event ring entry
	typedef struct packed {
		logic [TOKEN_W-1:0] token;
		logic [ID_W-1:0]    id;
	} ring_entry_t;

endpackage

/* design/ostq_cell.sv */
// one timeout slot cell of the rotating slot row
// depends on ostq_pkg
module ostq_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          shift,
	input  ostq_pkg::slot_t               in_slot,
	input  logic                          del_en,
	input  logic [ostq_pkg::ID_W-1:0]     del_id,
	output ostq_pkg::slot_t               slot
);
	import ostq_pkg::*;

	slot_t slot_q;
	logic  del_hit;

	// delete matches a nonzero id that maps back to this slot
	assign del_hit = del_en && (del_id != '0) && (slot_q.id == del_id) && !slot_q.nodel;

	// take the neighbour's slot while rotating, else clear its token and id on a delete hit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (shift) begin
			slot_q <= in_slot;
		end else if (del_hit) begin
			slot_q.token <= '0;
			slot_q.id    <= '0;
		end
	end

	assign slot = slot_q;

endmodule

/* design/ostq_ring.sv */
// event ring storage: one write port, one registered read port
// depends on ostq_pkg
module ostq_ring #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned AW    = 5
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  ostq_pkg::ring_entry_t wr_data,
	input  logic [AW-1:0]         rd_addr,
	output ostq_pkg::ring_entry_t rd_data
);
	import ostq_pkg::*;

	ring_entry_t mem [DEPTH];
	ring_entry_t rd_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

/* design/oneshot_timeout_slots_with_event_queue.sv */
// top level: one-shot timeout slots on a rotating cell row plus an event ring
// depends on ostq_pkg, ostq_cell, ostq_ring
//
//  channel | dir | payload
//  s_*     | in  | tuser: op; tdata: token, delay_ms, timeout_id
//  m_*     | out | tuser: status; tdata: id_out, token_out, dispatch
//
// post, delete, tick without expiry, shutdown, spare codes, a refused add and
// a dequeue of an empty ring pass the states EXEC and RESP; any other dequeue
// adds READ (registered ring read); an accepted add and an expiring tick add
// ADD or EXP, one slot passing the head cell each cycle as the row rotates once
// asynchronous active-low reset; a waiting result does not block acceptance,
// but a new result waits until the previous one is taken
module oneshot_timeout_slots_with_event_queue #(
	parameter int unsigned RING_DEPTH = 32,
	parameter int unsigned SLOT_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [2:0]  s_tuser,  // op
	input  logic [71:0] s_tdata,  // token, delay_ms, timeout_id, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [2:0]  m_tuser,  // status
	output logic [47:0] m_tdata   // id_out, token_out, dispatch
);
	import ostq_pkg::*;

	localparam int unsigned RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int unsigned KW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [RW-1:0] RING_LAST = RW'(RING_DEPTH - 1);
	localparam logic [KW-1:0] SLOT_LAST = KW'(SLOT_COUNT - 1);
	localparam logic [RW:0]   RING_FULL_LEN = (RW+1)'(RING_DEPTH - 1);
	localparam logic [RW:0]   RING_SIZE = (RW+1)'(RING_DEPTH);
	localparam logic [31:0]   ID_MASK = 32'h7FFF_FFFF;
	// a wrapped id still maps to its slot only when the slot count divides 2^31
	localparam logic          WRAP_NODEL = ((64'h8000_0000 % SLOT_COUNT) != 0);

	state_t state_q, state_d;

	// command registers
	op_t                op_q;
	logic [TOKEN_W-1:0] token_q;
	logic [DELAY_W-1:0] delay_q;
	logic [ID_W-1:0]    tid_q;

	// result registers
	status_t            res_status_q;
	logic [ID_W-1:0]    res_id_q;
	logic [TOKEN_W-1:0] res_tok_q;
	logic               res_disp_q;

	// output registers
	logic        m_tvalid_q;
	logic [2:0]  m_tuser_q;
	logic [47:0] m_tdata_q;

	// timer and ring state
	logic [RW-1:0]      put_q, get_q;
	logic [ID_W-1:0]    evcnt_q;
	logic               shut_q;
	logic               idle_q;
	logic [DELAY_W-1:0] nearest_q, period_q, done_q, dt_q;
	logic [ID_W-1:0]    base_q;
	logic [KW-1:0]      k_q;
	logic               found_q;

	// slot row
	slot_t              cell_out [SLOT_COUNT];
	slot_t              head_new;
	logic [SLOT_COUNT-1:0] free_vec;
	logic               any_free;
	logic               shift;
	logic               del_en;

	// ring access
	logic               push_req, ring_full, wr_en;
	ring_entry_t        push_entry, rd_data;
	logic [RW:0]        ring_len;

	logic               beat_in, out_free, last_k;

	assign beat_in  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign shift    = (state_q == S_ADD) || (state_q == S_EXP);
	assign del_en   = (state_q == S_EXEC) && (op_q == OP_DEL);
	assign last_k   = (k_q == SLOT_LAST);

	// cell row: each cell takes its upper neighbour, the top one takes the head result
	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		slot_t nb_slot;
		if (i == SLOT_COUNT - 1) begin : g_top
			assign nb_slot = head_new;
		end else begin : g_mid
			assign nb_slot = cell_out[i+1];
		end
		ostq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (shift),
			.in_slot (nb_slot),
			.del_en  (del_en),
			.del_id  (tid_q),
			.slot    (cell_out[i])
		);
		assign free_vec[i] = (cell_out[i].token == '0);
	end
	assign any_free = |free_vec;

	// ring occupancy
	always_comb begin
		if (put_q >= get_q) begin
			ring_len = {1'b0, put_q} - {1'b0, get_q};
		end else begin
			ring_len = {1'b0, put_q} + RING_SIZE - {1'b0, get_q};
		end
	end
	assign ring_full = (ring_len >= RING_FULL_LEN);
	assign wr_en     = push_req && !ring_full;

	ostq_ring #(.DEPTH(RING_DEPTH), .AW(RW)) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (put_q),
		.wr_data (push_entry),
		.rd_addr (get_q),
		.rd_data (rd_data)
	);

	// head cell processing and ring push source
	logic [31:0]        id_sum;
	logic [DELAY_W-1:0] exp_rem;
	logic [DELAY_W-1:0] min_d;
	logic [ID_W-1:0]    evcnt_inc;
	always_comb begin
		head_new   = cell_out[0];
		push_req   = 1'b0;
		push_entry = '0;
		id_sum     = {1'b0, base_q} + 32'(k_q);
		exp_rem    = cell_out[0].rem - dt_q;
		min_d      = nearest_q;
		evcnt_inc  = evcnt_q + 1'b1;
		unique case (state_q)
			S_ADD: begin
				if (!found_q && (cell_out[0].token == '0)) begin
					head_new.token = token_q;
					head_new.id    = id_sum[ID_W-1:0];
					head_new.rem   = delay_q;
					head_new.nodel = (id_sum > ID_MASK) && WRAP_NODEL;
				end else if (!idle_q && (cell_out[0].token != '0) && (cell_out[0].rem != '0)) begin
					head_new.rem = (cell_out[0].rem > done_q) ? cell_out[0].rem - done_q : '0;
				end
			end
			S_EXP: begin
				if (cell_out[0].token != '0) begin
					if (cell_out[0].rem <= dt_q) begin
						push_req         = 1'b1;
						push_entry.token = cell_out[0].token;
						push_entry.id    = cell_out[0].id;
						head_new         = '0;
					end else begin
						head_new.rem = exp_rem;
						if ((nearest_q == '0) || (nearest_q > exp_rem)) begin
							min_d = exp_rem;
						end
					end
				end
			end
			S_EXEC: begin
				if ((op_q == OP_POST) && !shut_q) begin
					push_req         = 1'b1;
					push_entry.token = token_q;
					push_entry.id    = evcnt_inc;
				end
			end
			default: begin
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (beat_in) state_d = S_EXEC;
			S_EXEC: begin
				priority case (1'b1)
					(op_q == OP_ADD) && !shut_q && any_free: state_d = S_ADD;
					(op_q == OP_TICK) && !idle_q && (period_q <= DELAY_W'(1)): state_d = S_EXP;
					(op_q == OP_DEQ) && (put_q != get_q): state_d = S_READ;
					default: state_d = S_RESP;
				endcase
			end
			S_ADD, S_EXP: if (last_k) state_d = S_RESP;
			S_READ: state_d = S_RESP;
			S_RESP: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// command capture; an add with zero delay has its delay raised to one
	always_ff @(posedge clk) begin
		if (beat_in) begin
			op_q    <= op_t'(s_tuser);
			token_q <= s_tdata[15:0];
			delay_q <= s_tdata[39:16];
			tid_q   <= s_tdata[70:40];
		end else if ((state_q == S_EXEC) && (op_q == OP_ADD) && (delay_q == '0)) begin
			delay_q <= DELAY_W'(1);
		end
	end

	// timer, ring indices and results
	logic [31:0] nb_sum;
	assign nb_sum = {1'b0, base_q} + 32'(SLOT_COUNT);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			put_q        <= '0;
			get_q        <= '0;
			evcnt_q      <= '0;
			shut_q       <= 1'b0;
			idle_q       <= 1'b1;
			nearest_q    <= '0;
			period_q     <= '0;
			done_q       <= '0;
			dt_q         <= '0;
			base_q       <= '0;
			k_q          <= '0;
			found_q      <= 1'b0;
			res_status_q <= ST_OK;
			res_id_q     <= '0;
			res_tok_q    <= '0;
			res_disp_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				put_q <= (put_q == RING_LAST) ? '0 : put_q + 1'b1;
			end
			unique case (state_q)
				S_EXEC: begin
					res_tok_q    <= '0;
					res_disp_q   <= 1'b0;
					k_q          <= '0;
					found_q      <= 1'b0;
					unique case (op_q)
						OP_POST: begin
							if (shut_q) begin
								res_status_q <= ST_SHUT;
								res_id_q     <= '0;
							end else begin
								evcnt_q <= evcnt_inc;
								if (ring_full) begin
									res_status_q <= ST_FULL;
									res_id_q     <= '0;
								end else begin
									res_status_q <= ST_OK;
									res_id_q     <= evcnt_inc;
								end
							end
						end
						OP_ADD: begin
							res_id_q <= '0;
							if (shut_q) begin
								res_status_q <= ST_SHUT;
							end else if (!any_free) begin
								res_status_q <= ST_NO_SLOT;
							end else begin
								res_status_q <= ST_OK;
								base_q <= (nb_sum > ID_MASK) ? '0 : nb_sum[ID_W-1:0];
								done_q <= (nearest_q >= period_q) ? nearest_q - period_q : '0;
							end
						end
						OP_TICK: begin
							res_status_q <= ST_OK;
							res_id_q     <= '0;
							if (!idle_q) begin
								if (period_q <= DELAY_W'(1)) begin
									period_q  <= '0;
									dt_q      <= nearest_q;
									nearest_q <= '0;
								end else begin
									period_q <= period_q - 1'b1;
								end
							end
						end
						OP_DEQ: begin
							res_id_q <= '0;
							if (put_q == get_q) begin
								res_status_q <= ST_EMPTY;
							end else begin
								res_status_q <= ST_OK;
								get_q <= (get_q == RING_LAST) ? '0 : get_q + 1'b1;
							end
						end
						OP_SHUT: begin
							res_status_q <= ST_OK;
							res_id_q     <= '0;
							shut_q       <= 1'b1;
							put_q        <= '0;
							get_q        <= '0;
						end
						default: begin
							res_status_q <= ST_OK;
							res_id_q     <= '0;
						end
					endcase
				end
				S_ADD: begin
					k_q <= last_k ? '0 : k_q + 1'b1;
					if (!found_q && (cell_out[0].token == '0)) begin
						found_q  <= 1'b1;
						res_id_q <= id_sum[ID_W-1:0];
					end
					if (last_k) begin
						idle_q <= 1'b0;
						if (idle_q || (delay_q < period_q)) begin
							nearest_q <= delay_q;
							period_q  <= delay_q;
						end else begin
							nearest_q <= period_q;
						end
					end
				end
				S_EXP: begin
					k_q       <= last_k ? '0 : k_q + 1'b1;
					nearest_q <= min_d;
					if (last_k) begin
						if (min_d != '0) period_q <= min_d;
						else             idle_q   <= 1'b1;
					end
				end
				S_READ: begin
					res_tok_q  <= rd_data.token;
					res_id_q   <= rd_data.id;
					res_disp_q <= (rd_data.token != '0);
				end
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			m_tuser_q  <= '0;
			m_tdata_q  <= '0;
		end else if ((state_q == S_RESP) && out_free) begin
			m_tvalid_q <= 1'b1;
			m_tuser_q  <= res_status_q;
			m_tdata_q  <= {res_disp_q, res_tok_q, res_id_q};
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

	// the row is back in slot order whenever a beat can be taken
	a_row_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (k_q == '0))
		else $error("slot row not aligned at idle");

	// an armed timer always has time left between beats
	a_armed_period: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_IDLE) && !idle_q) |-> (period_q != '0))
		else $error("armed timer with no period left");

	// a ring write always leaves the ring non-empty, so no entry is lost to a wrap
	a_ring_room: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (ring_len != '0))
		else $error("ring write lost");

endmodule

/* dv/oneshot_timeout_slots_with_event_queue_tb.sv */
// testbench for the one-shot timeout slots with event ring
// depends on ostq_pkg and oneshot_timeout_slots_with_event_queue
`timescale 1ns / 100ps

module oneshot_timeout_slots_with_event_queue_tb;
	import ostq_pkg::*;

	localparam int unsigned RDEPTH = 32;
	localparam int unsigned NSLOT  = 16;

	typedef struct packed {
		logic [2:0]  status;
		logic [30:0] id;
		logic [15:0] token;
		logic        disp;
	} answer_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [2:0]  s_tuser;
	logic [71:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [2:0]  m_tuser;
	logic [47:0] m_tdata;

	oneshot_timeout_slots_with_event_queue u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata)
	);

	// predictor state
	logic [15:0] rq_tok [RDEPTH];
	logic [30:0] rq_id  [RDEPTH];
	int unsigned put_ix, get_ix;
	logic [30:0] ev_count;
	bit          shut_on, tmr_idle;
	logic [23:0] near_dt, per_left;
	logic [31:0] id_base;
	logic [15:0] sl_tok [NSLOT];
	logic [30:0] sl_id  [NSLOT];
	logic [24:0] sl_rem [NSLOT];

	answer_t     pending_answers[$];
	int          fail_count;
	bit          quiet_tail;
	logic [30:0] recent_ids[$];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("oneshot_timeout_slots_with_event_queue verification failed");
		$finish;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
		$display("mismatch %s: got %0h expected %0h", what, got, exp);
		fail_count++;
	endtask

	function automatic bit ring_store(input logic [15:0] t, input logic [30:0] i);
		if (((put_ix + RDEPTH - get_ix) % RDEPTH) >= RDEPTH - 1) return 1'b0;
		rq_tok[put_ix] = t;
		rq_id[put_ix]  = i;
		put_ix = (put_ix + 1) % RDEPTH;
		return 1'b1;
	endfunction

	function automatic void expire_slots();
		logic [24:0] dt;
		dt = {1'b0, near_dt};
		near_dt = '0;
		for (int k = 0; k < NSLOT; k++) begin
			if (sl_tok[k] == 0) continue;
			if (sl_rem[k] <= dt) begin
				sl_rem[k] = '0;
				void'(ring_store(sl_tok[k], sl_id[k]));
				sl_tok[k] = '0;
				sl_id[k]  = '0;
			end else begin
				sl_rem[k] = sl_rem[k] - dt;
				if (near_dt == 0 || near_dt > sl_rem[k]) near_dt = sl_rem[k][23:0];
			end
		end
		if (near_dt > 0) per_left = near_dt;
		else tmr_idle = 1'b1;
	endfunction

	function automatic void arm_timer(input logic [23:0] dly, input int slot);
		logic [23:0] done;
		if (tmr_idle) begin
			near_dt = dly;
			tmr_idle = 1'b0;
		end else begin
			done = (near_dt >= per_left) ? near_dt - per_left : '0;
			for (int k = 0; k < NSLOT; k++) begin
				if (k == slot || sl_tok[k] == 0 || sl_rem[k] == 0) continue;
				sl_rem[k] = (sl_rem[k] > {1'b0, done}) ? sl_rem[k] - {1'b0, done} : '0;
			end
			near_dt = (per_left < dly) ? per_left : dly;
		end
		per_left = near_dt;
	endfunction

	function automatic answer_t predict_answer(input logic [2:0] op, input logic [15:0] tok,
			input logic [23:0] dly, input logic [30:0] tid);
		answer_t a;
		int k;
		logic [31:0] nb;
		logic [3:0]  ix;
		a = '0;
		ix = 4'(tid % NSLOT);
		case (op)
			OP_POST: begin
				if (shut_on) a.status = ST_SHUT;
				else begin
					ev_count = ev_count + 1'b1;
					if (ring_store(tok, ev_count)) a.id = ev_count;
					else a.status = ST_FULL;
				end
			end
			OP_ADD: begin
				if (shut_on) a.status = ST_SHUT;
				else begin
					for (k = 0; k < NSLOT; k++) if (sl_tok[k] == 0) break;
					if (k >= NSLOT) a.status = ST_NO_SLOT;
					else begin
						if (dly == 0) dly = 24'd1;
						nb = id_base + NSLOT;
						id_base = (nb > 32'h7fff_ffff) ? '0 : nb;
						sl_tok[k] = tok;
						sl_id[k]  = 31'(id_base + 32'(k));
						sl_rem[k] = {1'b0, dly};
						arm_timer(dly, k);
						a.id = sl_id[k];
						recent_ids.push_back(a.id);
					end
				end
			end
			OP_DEL: begin
				if (tid > 0 && sl_id[ix] == tid) begin
					sl_tok[ix] = '0;
					sl_id[ix]  = '0;
				end
			end
			OP_TICK: begin
				if (!tmr_idle) begin
					per_left = (per_left > 0) ? per_left - 1'b1 : '0;
					if (per_left == 0) expire_slots();
				end
			end
			OP_DEQ: begin
				if (put_ix == get_ix) a.status = ST_EMPTY;
				else begin
					a.token = rq_tok[get_ix];
					a.id    = rq_id[get_ix];
					a.disp  = (a.token != 0);
					rq_tok[get_ix] = '0;
					get_ix = (get_ix + 1) % RDEPTH;
				end
			end
			OP_SHUT: begin
				shut_on = 1'b1;
				put_ix = 0;
				get_ix = 0;
			end
			default: ;
		endcase
		return a;
	endfunction

	// occasional idle gap before the sender moves on, none in the quiet tail
	task automatic maybe_idle();
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic send_beat(input logic [2:0] op, input logic [15:0] tok,
			input logic [23:0] dly, input logic [30:0] tid);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {1'b0, tid, dly, tok};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_answers.push_back(predict_answer(op, tok, dly, tid));
		maybe_idle();
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// result checker with random back-pressure, none in the quiet tail
	initial begin : result_checker
		answer_t e;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (pending_answers.size() == 0) report("unexpected beat", m_tdata[31:0], 32'd0);
				else begin
					e = pending_answers.pop_front();
					if (m_tuser !== e.status)
						report("status", 32'(m_tuser), 32'(e.status));
					if (m_tdata[30:0] !== e.id)
						report("id_out", 32'(m_tdata[30:0]), 32'(e.id));
					if (m_tdata[46:31] !== e.token)
						report("token_out", 32'(m_tdata[46:31]), 32'(e.token));
					if (m_tdata[47] !== e.disp)
						report("dispatch", 32'(m_tdata[47]), 32'(e.disp));
				end
			end
			if (!quiet_tail && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	task automatic test_extremes();
		send_beat(OP_DEQ, 16'h0, 24'h0, 31'h0);
		send_beat(OP_TICK, 16'h0, 24'h0, 31'h0);
		send_beat(OP_DEL, 16'h0, 24'h0, 31'h0);
		send_beat(OP_POST, 16'hffff, 24'hffffff, 31'h7fffffff);
		send_beat(OP_POST, 16'h0, 24'h0, 31'h0);
		send_beat(OP_DEQ, 16'h0, 24'h0, 31'h0);
		send_beat(OP_DEQ, 16'h0, 24'h0, 31'h0);
		send_beat(OP_ADD, 16'h0, 24'h0, 31'h0);
		send_beat(OP_TICK, 16'h0, 24'h0, 31'h0);
		send_beat(OP_ADD, 16'hffff, 24'hffffff, 31'h7fffffff);
		send_beat(OP_ADD, 16'h1234, 24'd2, 31'h0);
		send_beat(OP_DEL, 16'h0, 24'h0, 31'h7fffffff);
		send_beat(OP_DEL, 16'h0, 24'h0, 31'd33);
		send_beat(OP_TICK, 16'h0, 24'h0, 31'h0);
		send_beat(OP_TICK, 16'h0, 24'h0, 31'h0);
		send_beat(OP_DEQ, 16'h0, 24'h0, 31'h0);
		send_beat(OP_NONE6, 16'hffff, 24'hffffff, 31'h7fffffff);
		send_beat(OP_NONE7, 16'h0, 24'h0, 31'h0);
		drain();
	endtask

	task automatic test_full_ring_and_slots();
		for (int i = 0; i < 33; i++) send_beat(OP_POST, 16'($urandom), 24'h0, 31'h0);
		for (int i = 0; i < 17; i++) send_beat(OP_ADD, 16'($urandom_range(1, 65535)),
				24'($urandom_range(1, 6)), 31'h0);
		for (int i = 0; i < 8; i++) send_beat(OP_TICK, 16'h0, 24'h0, 31'h0);
		for (int i = 0; i < 33; i++) send_beat(OP_DEQ, 16'h0, 24'h0, 31'h0);
		drain();
	endtask

	// mix of posts, adds, ticks, dequeues, deletes (mostly of ids from earlier adds) and spare codes, with noise
	task automatic test_random_traffic(input int n, input bit with_shutdown);
		logic [30:0] tid;
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (with_shutdown && i == n / 2)
				send_beat(OP_SHUT, 16'($urandom), 24'($urandom), 31'($urandom));
			else if (pick < 20)
				send_beat(OP_POST, 16'($urandom), 24'($urandom), 31'($urandom));
			else if (pick < 40) send_beat(OP_ADD, 16'($urandom),
					($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 12)),
					31'($urandom));
			else if (pick < 52) begin
				tid = (recent_ids.size() != 0 && $urandom_range(0, 2) != 0)
					? recent_ids[$urandom_range(0, recent_ids.size() - 1)] : 31'($urandom);
				send_beat(OP_DEL, 16'($urandom), 24'($urandom), tid);
			end else if (pick < 78)
				send_beat(OP_TICK, 16'($urandom), 24'($urandom), 31'($urandom));
			else if (pick < 97)
				send_beat(OP_DEQ, 16'($urandom), 24'($urandom), 31'($urandom));
			else send_beat(3'($urandom_range(6, 7)), 16'($urandom), 24'($urandom),
					31'($urandom));
			if (i == n / 4) drain();
		end
		drain();
	endtask

	initial begin : main_seq
		fail_count = 0;
		quiet_tail = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = '0;
		s_tdata = '0;
		put_ix = 0; get_ix = 0; ev_count = '0;
		shut_on = 1'b0; tmr_idle = 1'b1;
		near_dt = '0; per_left = '0; id_base = '0;
		for (int k = 0; k < RDEPTH; k++) begin rq_tok[k] = '0; rq_id[k] = '0; end
		for (int k = 0; k < NSLOT; k++) begin sl_tok[k] = '0; sl_id[k] = '0; sl_rem[k] = '0; end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_full_ring_and_slots();
		test_random_traffic(300, 1'b0);
		quiet_tail = 1'b1;
		test_random_traffic(200, 1'b1);
		if (fail_count == 0) begin
			$display("oneshot_timeout_slots_with_event_queue verification clean");
		end else begin
			$display("oneshot_timeout_slots_with_event_queue verification failed");
		end
		$finish;
	end

endmodule
